>>> rtl/core/fuzzy_relation_checker_closure_macros.svh
// assertion macros used by the checker file frc_checker.sv
`ifndef FUZZY_RELATION_CHECKER_CLOSURE_MACROS_SVH
`define FUZZY_RELATION_CHECKER_CLOSURE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define FRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frc assertion failed");

// consequent holds in the cycle after the antecedent
`define FRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frc assertion failed");

`endif

>>> rtl/core/frc_pkg.sv
// shared types and constants of the fuzzy relation checker
`timescale 1ns / 1ps
package frc_pkg;

   localparam int CFG_W                       = 4;
   localparam int IDX_W                       = 3;
   localparam int MAX_DIM_DEFAULT             = 8;
   localparam int GRADE_FRACTION_BITS_DEFAULT = 8;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_HEADER,
      OP_STEP,
      OP_EMIT
   } frc_op_type;

   typedef struct packed {
      frc_op_type       op;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] y;
      logic [IDX_W-1:0] z;
      logic             last;
      logic             scan_init;
   } frc_cmd_type;

endpackage

>>> rtl/core/frc_ctrl.sv
// controller: load, scan and emit sequencing with index counters
`timescale 1ns / 1ps
module frc_ctrl #(
   parameter int MAX_DIM = frc_pkg::MAX_DIM_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       csr_write_enable,
   input  logic [frc_pkg::CFG_W-1:0]  csr_write_data,
   output logic                       busy,
   output frc_pkg::frc_cmd_type       cmd
);
   import frc_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_DIM);

   state_type        state_ff;
   logic             busy_ff;
   logic             hdr_ff;
   logic [CFG_W-1:0] dim_ff;
   logic [IDX_W-1:0] x_ff;
   logic [IDX_W-1:0] y_ff;
   logic [IDX_W-1:0] z_ff;
   logic [IDX_W-1:0] ld_r_ff;
   logic [IDX_W-1:0] ld_c_ff;

   logic [CFG_W-1:0] dim_n;
   logic [IDX_W-1:0] end_idx;
   logic             accept;
   logic             load_done;

   always_comb begin
      priority if (dim_ff == '0) begin
         dim_n = CFG_W'(1);
      end else if (dim_ff > MAX_N) begin
         dim_n = MAX_N;
      end else begin
         dim_n = dim_ff;
      end
   end

   assign end_idx   = IDX_W'(dim_n - CFG_W'(1));
   assign accept    = start && !busy_ff;
   assign load_done = (ld_r_ff == end_idx) && (ld_c_ff == end_idx);
   assign busy      = busy_ff;

   always_comb begin
      cmd = '{op: OP_IDLE, x: '0, y: '0, z: '0, last: 1'b0, scan_init: 1'b0};
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.op        = OP_LOAD;
               cmd.x         = ld_r_ff;
               cmd.y         = ld_c_ff;
               cmd.scan_init = load_done;
            end
         end
         ST_SCAN: begin
            cmd.op = hdr_ff ? OP_HEADER : OP_STEP;
            cmd.x  = x_ff;
            cmd.y  = y_ff;
            cmd.z  = z_ff;
         end
         ST_EMIT: begin
            cmd.op   = OP_EMIT;
            cmd.x    = x_ff;
            cmd.y    = y_ff;
            cmd.last = (x_ff == end_idx) && (y_ff == end_idx);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         busy_ff  <= 1'b0;
         hdr_ff   <= 1'b1;
         dim_ff   <= MAX_N;
         x_ff     <= '0;
         y_ff     <= '0;
         z_ff     <= '0;
         ld_r_ff  <= '0;
         ld_c_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (load_done) begin
                     state_ff <= ST_SCAN;
                     busy_ff  <= 1'b1;
                     hdr_ff   <= 1'b1;
                     x_ff     <= '0;
                     y_ff     <= '0;
                     z_ff     <= '0;
                     ld_r_ff  <= '0;
                     ld_c_ff  <= '0;
                  end else if (ld_c_ff == end_idx) begin
                     ld_c_ff <= '0;
                     ld_r_ff <= ld_r_ff + IDX_W'(1);
                  end else begin
                     ld_c_ff <= ld_c_ff + IDX_W'(1);
                  end
               end
            end
            ST_SCAN: begin
               if (hdr_ff) begin
                  hdr_ff <= 1'b0;
                  z_ff   <= '0;
               end else if (z_ff == end_idx) begin
                  hdr_ff <= 1'b1;
                  z_ff   <= '0;
                  if (y_ff == end_idx) begin
                     y_ff <= '0;
                     if (x_ff == end_idx) begin
                        x_ff     <= '0;
                        state_ff <= ST_EMIT;
                     end else begin
                        x_ff <= x_ff + IDX_W'(1);
                     end
                  end else begin
                     y_ff <= y_ff + IDX_W'(1);
                  end
               end else begin
                  z_ff <= z_ff + IDX_W'(1);
               end
            end
            ST_EMIT: begin
               if (y_ff == end_idx) begin
                  y_ff <= '0;
                  if (x_ff == end_idx) begin
                     x_ff     <= '0;
                     state_ff <= ST_LOAD;
                     busy_ff  <= 1'b0;
                  end else begin
                     x_ff <= x_ff + IDX_W'(1);
                  end
               end else begin
                  y_ff <= y_ff + IDX_W'(1);
               end
            end
            default: begin
               state_ff <= ST_LOAD;
               busy_ff  <= 1'b0;
            end
         endcase
         if (csr_write_enable) begin
            dim_ff  <= csr_write_data;
            ld_r_ff <= '0;
            ld_c_ff <= '0;
         end
      end
   end

endmodule

>>> rtl/core/frc_dp.sv
// datapath: relation and closure stores, flag checks, warshall update, result beat
`timescale 1ns / 1ps
module frc_dp #(
   parameter int MAX_DIM             = frc_pkg::MAX_DIM_DEFAULT,
   parameter int GRADE_FRACTION_BITS = frc_pkg::GRADE_FRACTION_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  frc_pkg::frc_cmd_type           cmd,
   input  logic [GRADE_FRACTION_BITS:0]   req_grade,
   output logic                           rsp_valid,
   output logic [frc_pkg::IDX_W-1:0]      rsp_row,
   output logic [frc_pkg::IDX_W-1:0]      rsp_column,
   output logic [GRADE_FRACTION_BITS:0]   rsp_closure_grade,
   output logic                           rsp_reflexive,
   output logic                           rsp_antireflexive,
   output logic                           rsp_symmetric,
   output logic                           rsp_antisymmetric,
   output logic                           rsp_transitive,
   output logic                           rsp_last
);
   import frc_pkg::*;

   localparam int GW     = GRADE_FRACTION_BITS + 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [GW-1:0] ONE = {1'b1, {GRADE_FRACTION_BITS{1'b0}}};

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   logic [GW-1:0] rel_mem [DEPTH];
   logic [GW-1:0] clo_mem [DEPTH];

   logic [GW-1:0] rel_a_ff;
   logic [GW-1:0] rel_b_ff;
   logic [GW-1:0] clo_a_ff;
   logic [GW-1:0] clo_b_ff;

   frc_cmd_type   cmd_q_ff;
   logic [GW-1:0] aij_ff;
   logic          colnz_ff;
   logic          refl_ff;
   logic          anti_ff;
   logic          sym_ff;
   logic          asym_ff;
   logic          trans_ff;

   logic [GW-1:0]     sat_grade;
   logic [ADDR_W-1:0] rel_ra;
   logic [ADDR_W-1:0] rel_rb;
   logic [ADDR_W-1:0] clo_ra;
   logic [ADDR_W-1:0] clo_rb;
   logic              load_we;
   logic              hit_we;
   logic              clo_we;
   logic [ADDR_W-1:0] clo_wa;
   logic [GW-1:0]     clo_wd;
   logic [GW-1:0]     step_min;

   assign sat_grade = (req_grade > ONE) ? ONE : req_grade;
   assign load_we   = (cmd.op == OP_LOAD);
   assign hit_we    = (cmd_q_ff.op == OP_STEP) && colnz_ff && (clo_b_ff != '0);
   assign clo_we    = hit_we || load_we;
   assign clo_wa    = hit_we ? addr_of(cmd_q_ff.y, cmd_q_ff.z) : addr_of(cmd.x, cmd.y);
   assign clo_wd    = hit_we ? ONE : sat_grade;
   assign step_min  = (rel_a_ff < rel_b_ff) ? rel_a_ff : rel_b_ff;

   always_comb begin
      rel_ra = addr_of(cmd.x, cmd.z);
      rel_rb = addr_of(cmd.z, cmd.y);
      clo_ra = addr_of(cmd.x, cmd.y);
      clo_rb = addr_of(cmd.x, cmd.z);
      unique case (cmd.op)
         OP_HEADER: begin
            rel_ra = addr_of(cmd.x, cmd.y);
            rel_rb = addr_of(cmd.y, cmd.x);
            clo_ra = addr_of(cmd.y, cmd.x);
         end
         OP_IDLE, OP_LOAD, OP_STEP, OP_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         rel_mem[addr_of(cmd.x, cmd.y)] <= sat_grade;
      end
      rel_a_ff <= rel_mem[rel_ra];
      rel_b_ff <= rel_mem[rel_rb];
   end

   // write-through so a read in the cycle of a write sees the new grade
   always_ff @(posedge clock) begin
      if (clo_we) begin
         clo_mem[clo_wa] <= clo_wd;
      end
      clo_a_ff <= (clo_we && (clo_wa == clo_ra)) ? clo_wd : clo_mem[clo_ra];
      clo_b_ff <= (clo_we && (clo_wa == clo_rb)) ? clo_wd : clo_mem[clo_rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_q_ff.op <= OP_IDLE;
      end else begin
         cmd_q_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_q_ff.op == OP_HEADER) begin
         aij_ff   <= rel_a_ff;
         colnz_ff <= (clo_a_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.scan_init) begin
         refl_ff  <= 1'b1;
         anti_ff  <= 1'b1;
         sym_ff   <= 1'b1;
         asym_ff  <= 1'b1;
         trans_ff <= 1'b1;
      end else if (cmd_q_ff.op == OP_HEADER) begin
         if (cmd_q_ff.x == cmd_q_ff.y) begin
            if (rel_a_ff != ONE) refl_ff <= 1'b0;
            if (rel_a_ff != '0)  anti_ff <= 1'b0;
         end else if ((rel_a_ff != '0) && (rel_b_ff != '0)) begin
            asym_ff <= 1'b0;
         end
         if (rel_a_ff != rel_b_ff) sym_ff <= 1'b0;
      end else if (cmd_q_ff.op == OP_STEP) begin
         if (aij_ff < step_min) trans_ff <= 1'b0;
      end else begin
      end
   end

   assign rsp_valid         = (cmd_q_ff.op == OP_EMIT);
   assign rsp_row           = cmd_q_ff.x;
   assign rsp_column        = cmd_q_ff.y;
   assign rsp_closure_grade = clo_a_ff;
   assign rsp_reflexive     = refl_ff;
   assign rsp_antireflexive = anti_ff;
   assign rsp_symmetric     = sym_ff;
   assign rsp_antisymmetric = asym_ff;
   assign rsp_transitive    = trans_ff;
   assign rsp_last          = cmd_q_ff.last;

endmodule

>>> rtl/core/fuzzy_relation_checker_closure.sv
// top level of the fuzzy relation property checker with warshall closure
//
//   channel   ports                      handshake
//   request   req_grade                  beat taken when start high and busy low
//   response  rsp_row .. rsp_last        one beat per cycle with rsp_valid high
//   csr       csr_write_data             written when csr_write_enable high
//
// loading takes one grade per cycle while busy is low
// after the final grade, the scan walks both stores at once: flag checks read
// the relation store and the warshall pivots update the closure store
// then a closure store read and n*n response beats back to back; busy drops in
// the cycle of the last beat
// synchronous reset sets the dimension to MAX_DIM and restarts the load
// the receiver cannot stall; beats are never held
`timescale 1ns / 1ps
module fuzzy_relation_checker_closure #(
   parameter int MAX_DIM             = frc_pkg::MAX_DIM_DEFAULT,
   parameter int GRADE_FRACTION_BITS = frc_pkg::GRADE_FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [GRADE_FRACTION_BITS:0]  req_grade,
   input  logic                          csr_write_enable,
   input  logic [frc_pkg::CFG_W-1:0]     csr_write_data,
   output logic                          rsp_valid,
   output logic [frc_pkg::IDX_W-1:0]     rsp_row,
   output logic [frc_pkg::IDX_W-1:0]     rsp_column,
   output logic [GRADE_FRACTION_BITS:0]  rsp_closure_grade,
   output logic                          rsp_reflexive,
   output logic                          rsp_antireflexive,
   output logic                          rsp_symmetric,
   output logic                          rsp_antisymmetric,
   output logic                          rsp_transitive,
   output logic                          rsp_last
);
   import frc_pkg::*;

   frc_cmd_type cmd;

   frc_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_frc_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .cmd              (cmd)
   );

   frc_dp #(
      .MAX_DIM             (MAX_DIM),
      .GRADE_FRACTION_BITS (GRADE_FRACTION_BITS)
   ) u_frc_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_grade         (req_grade),
      .rsp_valid         (rsp_valid),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_closure_grade (rsp_closure_grade),
      .rsp_reflexive     (rsp_reflexive),
      .rsp_antireflexive (rsp_antireflexive),
      .rsp_symmetric     (rsp_symmetric),
      .rsp_antisymmetric (rsp_antisymmetric),
      .rsp_transitive    (rsp_transitive),
      .rsp_last          (rsp_last)
   );

endmodule

>>> rtl/core/frc_checker.sv
// port-level assertions for the fuzzy relation checker and their bind
`timescale 1ns / 1ps
`include "fuzzy_relation_checker_closure_macros.svh"
module frc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_reflexive,
   input logic rsp_antireflexive,
   input logic rsp_symmetric,
   input logic rsp_antisymmetric,
   input logic rsp_transitive,
   input logic rsp_last
);

   logic [4:0] flags;

   assign flags = {rsp_reflexive, rsp_antireflexive, rsp_symmetric, rsp_antisymmetric,
                   rsp_transitive};

   // no response beat right after a request beat is taken
   `FRC_ASSERT_NEXT(a_no_beat_after_load, clock, reset, start && !busy, !rsp_valid)
   // beats of one run come back to back
   `FRC_ASSERT_NEXT(a_run_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   // run ends after the last beat
   `FRC_ASSERT_NEXT(a_run_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid)
   // busy covers every beat but the last
   `FRC_ASSERT_NOW(a_busy_in_run, clock, reset, rsp_valid && !rsp_last, busy)
   // flags hold across a run
   `FRC_ASSERT_NEXT(a_flags_stable, clock, reset, rsp_valid && !rsp_last, $stable(flags))

endmodule

bind fuzzy_relation_checker_closure frc_checker u_frc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_reflexive     (rsp_reflexive),
   .rsp_antireflexive (rsp_antireflexive),
   .rsp_symmetric     (rsp_symmetric),
   .rsp_antisymmetric (rsp_antisymmetric),
   .rsp_transitive    (rsp_transitive),
   .rsp_last          (rsp_last)
);

>>> test/fuzzy_relation_checker_closure_tb.sv
// testbench for the fuzzy relation checker: property flags and warshall closure beats
`timescale 1ns / 1ps
module fuzzy_relation_checker_closure_tb;
   import frc_pkg::*;

   localparam int MAX_DIM       = MAX_DIM_DEFAULT;
   localparam int GW            = GRADE_FRACTION_BITS_DEFAULT + 1;
   localparam int GRADE_ONE     = 1 << GRADE_FRACTION_BITS_DEFAULT;
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int SETTLE_CYCLES = STORE_DEPTH * (MAX_DIM + 1) + STORE_DEPTH + 16;
   localparam int CSR_QUIET     = 4;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] column;
      logic [GW-1:0]    grade;
      logic             reflexive;
      logic             antireflexive;
      logic             symmetric;
      logic             antisymmetric;
      logic             transitive;
      logic             last;
   } closure_beat_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [GW-1:0]       req_grade;
   logic                csr_write_enable;
   logic [CFG_W-1:0]    csr_write_data;
   logic                rsp_valid;
   logic [IDX_W-1:0]    rsp_row;
   logic [IDX_W-1:0]    rsp_column;
   logic [GW-1:0]       rsp_closure_grade;
   logic                rsp_reflexive;
   logic                rsp_antireflexive;
   logic                rsp_symmetric;
   logic                rsp_antisymmetric;
   logic                rsp_transitive;
   logic                rsp_last;

   logic [GW-1:0]       relation_grades [STORE_DEPTH];
   logic [CFG_W-1:0]    dimension_reg;
   int unsigned         grades_loaded;
   closure_beat_type    closure_beats_due [$];

   int unsigned         sender_idle_pct;
   int unsigned         grades_sent;
   int unsigned         matrices_closed;
   int unsigned         beats_checked;
   int unsigned         mismatches;

   fuzzy_relation_checker_closure u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_grade         (req_grade),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_closure_grade (rsp_closure_grade),
      .rsp_reflexive     (rsp_reflexive),
      .rsp_antireflexive (rsp_antireflexive),
      .rsp_symmetric     (rsp_symmetric),
      .rsp_antisymmetric (rsp_antisymmetric),
      .rsp_transitive    (rsp_transitive),
      .rsp_last          (rsp_last)
   );

   always #4 clock = ~clock;

   // relation loading, property flags and closure for one accepted grade
   task automatic absorb_grade(input logic [GW-1:0] grade_in);
      int unsigned      n, total, i, j, k, x, y, d, a, b, lo;
      logic [GW-1:0]    g;
      logic             refl, anti, sym, asym, trans;
      logic [GW-1:0]    work [STORE_DEPTH];
      closure_beat_type beat;
      n = (dimension_reg == 0) ? 1 :
          (dimension_reg > MAX_DIM) ? MAX_DIM : 32'(dimension_reg);
      total = n * n;
      g = (grade_in > GRADE_ONE) ? GW'(GRADE_ONE) : grade_in;
      if (grades_loaded >= total) grades_loaded = 0;
      relation_grades[grades_loaded] = g;
      grades_loaded++;
      if (grades_loaded < total) return;
      grades_loaded = 0;
      matrices_closed++;
      refl = 1'b1; anti = 1'b1; sym = 1'b1; asym = 1'b1; trans = 1'b1;
      for (i = 0; i < n; i++) begin
         d = 32'(relation_grades[i*n+i]);
         if (d != GRADE_ONE) refl = 1'b0;
         if (d != 0) anti = 1'b0;
         for (j = i + 1; j < n; j++) begin
            a = 32'(relation_grades[i*n+j]);
            b = 32'(relation_grades[j*n+i]);
            if (a != b) sym = 1'b0;
            if (a != 0 && b != 0) asym = 1'b0;
         end
      end
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            for (k = 0; k < n; k++) begin
               x = 32'(relation_grades[i*n+k]);
               y = 32'(relation_grades[k*n+j]);
               lo = (x < y) ? x : y;
               if (relation_grades[i*n+j] < lo) trans = 1'b0;
            end
      work = relation_grades;
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            for (k = 0; k < n; k++)
               if (work[j*n+i] != 0 && work[i*n+k] != 0) work[j*n+k] = GW'(GRADE_ONE);
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) begin
            beat.row           = i[IDX_W-1:0];
            beat.column        = j[IDX_W-1:0];
            beat.grade         = work[i*n+j];
            beat.reflexive     = refl;
            beat.antireflexive = anti;
            beat.symmetric     = sym;
            beat.antisymmetric = asym;
            beat.transitive    = trans;
            beat.last          = (i*n + j + 1 == total);
            closure_beats_due.push_back(beat);
         end
   endtask

   task automatic note_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      closure_beat_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (closure_beats_due.size() == 0) begin
            $error("beat with nothing expected: row %0d column %0d grade %0d",
                   rsp_row, rsp_column, rsp_closure_grade);
            mismatches++;
         end else begin
            want = closure_beats_due.pop_front();
            beats_checked++;
            note_field("row", 32'(want.row), 32'(rsp_row));
            note_field("column", 32'(want.column), 32'(rsp_column));
            note_field("closure_grade", 32'(want.grade), 32'(rsp_closure_grade));
            note_field("reflexive", 32'(want.reflexive), 32'(rsp_reflexive));
            note_field("antireflexive", 32'(want.antireflexive), 32'(rsp_antireflexive));
            note_field("symmetric", 32'(want.symmetric), 32'(rsp_symmetric));
            note_field("antisymmetric", 32'(want.antisymmetric), 32'(rsp_antisymmetric));
            note_field("transitive", 32'(want.transitive), 32'(rsp_transitive));
            note_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_grade(input logic [GW-1:0] g);
      int unsigned gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_grade <= g;
      do @(posedge clock); while (busy !== 1'b0);
      absorb_grade(g);
      grades_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (closure_beats_due.size() != 0) @(negedge clock);
      repeat (CSR_QUIET) @(negedge clock);
   endtask

   task automatic write_dimension(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= CFG_W'($urandom_range(15));
      dimension_reg = value;
      grades_loaded = 0;
   endtask

   // builds a shaped n-by-n relation and sends its first count grades
   task automatic send_matrix(input int unsigned n, input int unsigned count);
      logic [GW-1:0] m [STORE_DEPTH];
      int unsigned   kind, r, c, fill;
      kind = $urandom_range(3);
      fill = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? GRADE_ONE : $urandom_range(1, 255));
      for (r = 0; r < n; r++)
         for (c = 0; c < n; c++)
            case (kind)
               0: m[r*n+c] = GW'($urandom_range((1 << GW) - 1));
               1: m[r*n+c] = ($urandom_range(9) < 7) ? '0 : GW'($urandom_range(1, GRADE_ONE));
               2: m[r*n+c] = $urandom_range(1) ? GW'(GRADE_ONE) : '0;
               default: m[r*n+c] = GW'(fill);
            endcase
      if ($urandom_range(9) < 3)
         for (r = 0; r < n; r++)
            for (c = r + 1; c < n; c++) m[c*n+r] = m[r*n+c];
      case ($urandom_range(9))
         0, 1, 2: for (r = 0; r < n; r++) m[r*n+r] = GW'(GRADE_ONE);
         3, 4:    for (r = 0; r < n; r++) m[r*n+r] = '0;
         default: ;
      endcase
      for (r = 0; r < count; r++) send_grade(m[r]);
   endtask

   task automatic test_default_dimension();
      send_matrix(MAX_DIM, STORE_DEPTH);
   endtask

   task automatic test_single_entry();
      write_dimension(4'd0);
      send_grade(9'd0);
      send_grade(9'h1FF);
      write_dimension(4'd1);
      send_grade(9'd256);
      send_grade(9'd257);
   endtask

   task automatic test_flag_patterns();
      write_dimension(4'd2);
      send_grade(9'd256); send_grade(9'd0);   send_grade(9'd0);   send_grade(9'd256);
      send_grade(9'd0);   send_grade(9'd128); send_grade(9'd128); send_grade(9'd0);
      send_grade(9'd0);   send_grade(9'd200); send_grade(9'd0);   send_grade(9'd0);
   endtask

   task automatic test_restart_mid_load();
      write_dimension(4'd3);
      send_grade(9'd77); send_grade(9'd256); send_grade(9'd5);
      write_dimension(4'd2);
      send_grade(9'd1); send_grade(9'd0); send_grade(9'd255); send_grade(9'd256);
   endtask

   task automatic test_random_relations(input int unsigned idle_pct, input int unsigned quota);
      int unsigned first, n, pick;
      logic [CFG_W-1:0] code;
      sender_idle_pct = idle_pct;
      first = grades_sent;
      while (grades_sent - first < quota) begin
         if ($urandom_range(9) < 7) begin
            pick = $urandom_range(99);
            if (pick < 8)       code = CFG_W'($urandom_range(MAX_DIM, 15));
            else if (pick < 16) code = '0;
            else                code = CFG_W'($urandom_range(1, 4));
            write_dimension(code);
         end
         n = (dimension_reg == 0) ? 1 :
             (dimension_reg > MAX_DIM) ? MAX_DIM : 32'(dimension_reg);
         if (n > 1 && $urandom_range(9) == 0) send_matrix(n, $urandom_range(1, n * n - 1));
         else send_matrix(n, n * n);
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_grade        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      dimension_reg    = CFG_W'(MAX_DIM);
      grades_loaded    = 0;
      sender_idle_pct  = 0;
      grades_sent      = 0;
      matrices_closed  = 0;
      beats_checked    = 0;
      mismatches       = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_dimension();
      test_single_entry();
      test_flag_patterns();
      test_restart_mid_load();
      test_random_relations(0, 20);
      test_random_relations(85, 20);
      test_random_relations(34, 20);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("run covered %0d grades, %0d closed relations, %0d closure beats checked",
               grades_sent, matrices_closed, beats_checked);
      $display("dimensions 0 to 15, saturated grades, restarts mid-load, sender gaps 0/85/34");
      if (mismatches == 0 && closure_beats_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/frc_pkg.sv
rtl/core/frc_ctrl.sv
rtl/core/frc_dp.sv
rtl/core/fuzzy_relation_checker_closure.sv
rtl/core/frc_checker.sv
test/fuzzy_relation_checker_closure_tb.sv
